// File: src/oscillator_trim_successive_approx_defines.svh
// ----------------------------------------------------------------------------
// oscillator trim calibration: assertion macros
// shared concurrent assertion forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef OSCILLATOR_TRIM_SUCCESSIVE_APPROX_DEFINES_SVH
`define OSCILLATOR_TRIM_SUCCESSIVE_APPROX_DEFINES_SVH

// same-cycle implication
`define OTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ots_pkg.sv
// ----------------------------------------------------------------------------
// oscillator trim calibration package
// widths, reset constants, request codes and payload types
// ----------------------------------------------------------------------------
package ots_pkg;

  localparam int TRIM_WIDTH    = 8;
  localparam int MEASURE_WIDTH = 14;
  localparam int STEP_WIDTH    = TRIM_WIDTH - 1;
  localparam int DEV_WIDTH     = (MEASURE_WIDTH > 14) ? MEASURE_WIDTH : 14;

  localparam logic [STEP_WIDTH-1:0]    STEP_START   = STEP_WIDTH'(1) << (TRIM_WIDTH - 2);
  localparam logic [TRIM_WIDTH-1:0]    REGION1_BASE = TRIM_WIDTH'(1) << (TRIM_WIDTH - 1);
  localparam logic [DEV_WIDTH-1:0]     DEV_RESET    = DEV_WIDTH'(9999);
  localparam logic [MEASURE_WIDTH-1:0] TARGET_RESET = MEASURE_WIDTH'(2356);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [MEASURE_WIDTH-1:0] measured_length;
  } ots_in_t;

  typedef struct packed {
    logic [TRIM_WIDTH-1:0] trim_value;
    logic                  done_res;
  } ots_out_t;

  typedef struct packed {
    logic                  busy;
    logic                  search_region;
    logic [STEP_WIDTH-1:0] step_size;
    logic [TRIM_WIDTH-1:0] trial_trim;
    logic [TRIM_WIDTH-1:0] best_trim;
    logic [DEV_WIDTH-1:0]  best_dev;
  } ots_state_t;

endpackage

// File: src/ots_step.sv
// ----------------------------------------------------------------------------
// oscillator trim calibration: search step
// deviation, best-trim update and next trial for one request
// ----------------------------------------------------------------------------
module ots_step (
  input  ots_pkg::ots_state_t                state_i,
  input  ots_pkg::ots_in_t                   item_i,
  input  logic [ots_pkg::MEASURE_WIDTH-1:0]  target_i,
  output ots_pkg::ots_state_t                state_o,
  output ots_pkg::ots_out_t                  result_o,
  output logic                               result_vld_o
);

  logic [ots_pkg::MEASURE_WIDTH-1:0] dev;
  logic [ots_pkg::DEV_WIDTH-1:0]     dev_ext;
  logic                              short_meas;
  logic [ots_pkg::STEP_WIDTH-1:0]    step_half;
  logic [ots_pkg::TRIM_WIDTH-1:0]    step_trim;

  assign short_meas = item_i.measured_length < target_i;
  assign dev        = short_meas ? (target_i - item_i.measured_length)
                                 : (item_i.measured_length - target_i);
  assign dev_ext    = ots_pkg::DEV_WIDTH'(dev);
  assign step_half  = state_i.step_size >> 1;
  assign step_trim  = ots_pkg::TRIM_WIDTH'(step_half);

  always_comb begin
    state_o      = state_i;
    result_o     = '0;
    result_vld_o = 1'b0;
    if (item_i.action == ots_pkg::ACT_START) begin
      state_o.busy           = 1'b1;
      state_o.search_region  = 1'b0;
      state_o.best_trim      = '0;
      state_o.best_dev       = ots_pkg::DEV_RESET;
      state_o.step_size      = ots_pkg::STEP_START;
      state_o.trial_trim     = ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START);
      result_o.trim_value    = ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START);
      result_vld_o           = 1'b1;
    end else if (state_i.busy) begin
      if (dev_ext < state_i.best_dev) begin
        state_o.best_trim = state_i.trial_trim;
        state_o.best_dev  = dev_ext;
      end
      state_o.step_size = step_half;
      result_vld_o      = 1'b1;
      if (step_half != '0) begin
        state_o.trial_trim = short_meas ? (state_i.trial_trim + step_trim)
                                        : (state_i.trial_trim - step_trim);
        result_o.trim_value = state_o.trial_trim;
      end else if (!state_i.search_region) begin
        state_o.search_region = 1'b1;
        state_o.step_size     = ots_pkg::STEP_START;
        state_o.trial_trim    = ots_pkg::REGION1_BASE
                              + ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START);
        result_o.trim_value   = state_o.trial_trim;
      end else begin
        state_o.busy        = 1'b0;
        result_o.trim_value = state_o.best_trim;
        result_o.done_res   = 1'b1;
      end
    end
  end

endmodule

// File: src/oscillator_trim_successive_approx.sv
// ----------------------------------------------------------------------------
// oscillator trim calibration by successive approximation
// binary search of the trim over two regions against a target frame length
//
//   channel  ports                        carries
//   in       in_valid in_ready in_data    start or measured length
//   out      out_valid out_ready out_data trial trim, or best trim with done
//   cfg      cfg_we cfg_wdata             target frame length
//
// one request per cycle sustained while the output is not stalled; a request
// waits in the input register, its result is registered in the output register
// the search state is updated in the same cycle the request leaves the
// input register, so the compare and update path sets the rate
// synchronous active-low reset; target returns to 2356, search goes idle
// a stalled output holds the result and the input register absorbs one more
// ----------------------------------------------------------------------------
`include "oscillator_trim_successive_approx_defines.svh"

module oscillator_trim_successive_approx (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ots_pkg::ots_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ots_pkg::ots_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [ots_pkg::MEASURE_WIDTH-1:0] cfg_wdata
);

  logic                              in_vld_r;
  ots_pkg::ots_in_t                  in_data_r;
  logic                              out_vld_r;
  ots_pkg::ots_out_t                 out_data_r;
  logic [ots_pkg::MEASURE_WIDTH-1:0] target_r;
  ots_pkg::ots_state_t               state_r;
  ots_pkg::ots_state_t               state_nxt;
  ots_pkg::ots_out_t                 res_nxt;
  logic                              res_vld;
  logic                              out_free;
  logic                              fire;

  assign out_free  = !out_vld_r || out_ready;
  assign fire      = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  ots_step u_step (
    .state_i      (state_r),
    .item_i       (in_data_r),
    .target_i     (target_r),
    .state_o      (state_nxt),
    .result_o     (res_nxt),
    .result_vld_o (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r              <= 1'b0;
      out_vld_r             <= 1'b0;
      target_r              <= ots_pkg::TARGET_RESET;
      state_r.busy          <= 1'b0;
      state_r.search_region <= 1'b0;
      state_r.step_size     <= ots_pkg::STEP_START;
      state_r.trial_trim    <= '0;
      state_r.best_trim     <= '0;
      state_r.best_dev      <= ots_pkg::DEV_RESET;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_vld_r <= fire && res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (fire && res_vld) begin
      out_data_r <= res_nxt;
    end
  end

  // search checks
  `OTS_ASSERT_NOW(a_step_pow2, 1'b1, (state_r.step_size == '0) || $onehot(state_r.step_size), "step size not a power of two")
  `OTS_ASSERT_NXT(a_done_idle, fire && res_vld && res_nxt.done_res, !state_r.busy, "busy held after final result")
  `OTS_ASSERT_NXT(a_start_trial, fire && (in_data_r.action == ots_pkg::ACT_START), out_vld_r && (out_data_r.trim_value == ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START)) && !out_data_r.done_res, "start did not issue first trial")
  `OTS_ASSERT_NXT(a_in_held, in_vld_r && !out_free, in_vld_r && $stable(in_data_r), "pending request lost")
  `OTS_ASSERT_NOW(a_idle_step, fire && !state_r.busy && (in_data_r.action == ots_pkg::ACT_MEASURE), !res_vld, "result from idle measurement")

endmodule

// File: tb/oscillator_trim_successive_approx_tb.sv
// ----------------------------------------------------------------------------
// oscillator trim calibration: self-checking testbench
// a directed table walks through start, a full search, an early restart and
// measurements while idle; random searches follow under several target
// lengths. results are checked in order against typed rows or a cycle-free
// copy of the search, with random stalls on both channels and one long output hold
// ----------------------------------------------------------------------------
module oscillator_trim_successive_approx_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEAS_MAX = (1 << ots_pkg::MEASURE_WIDTH) - 1;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD = 400;

  typedef struct {
    ots_pkg::ots_in_t  req;
    bit                typed;
    bit                silent;
    ots_pkg::ots_out_t res;
  } table_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  ots_pkg::ots_in_t                  in_data = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  ots_pkg::ots_out_t                 out_data;
  logic                              cfg_we = 1'b0;
  logic [ots_pkg::MEASURE_WIDTH-1:0] cfg_wdata = '0;

  // search state as the block should hold it
  logic [ots_pkg::MEASURE_WIDTH-1:0] cal_target = ots_pkg::TARGET_RESET;
  bit                                cal_busy = 1'b0;
  bit                                cal_region = 1'b0;
  logic [ots_pkg::STEP_WIDTH-1:0]    cal_step = ots_pkg::STEP_START;
  logic [ots_pkg::TRIM_WIDTH-1:0]    cal_trial = '0;
  logic [ots_pkg::TRIM_WIDTH-1:0]    cal_best = '0;
  logic [ots_pkg::DEV_WIDTH-1:0]     cal_best_dev = ots_pkg::DEV_RESET;

  ots_pkg::ots_out_t trims_due[$];
  table_row_t        directed[$];

  int  mismatches = 0;
  int  n_starts = 0;
  int  n_measures = 0;
  int  n_ignored = 0;
  int  n_done = 0;
  int  n_checked = 0;
  int  n_answered = 0;
  bit  feed_steady = 1'b0;
  bit  sink_steady = 1'b0;
  bit  long_hold_due = 1'b0;

  oscillator_trim_successive_approx dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic advance_calibration(input ots_pkg::ots_in_t req, output bit produced,
                                     output ots_pkg::ots_out_t res);
    logic [ots_pkg::MEASURE_WIDTH-1:0] meas;
    logic [ots_pkg::MEASURE_WIDTH-1:0] dev;
    meas = req.measured_length;
    produced = 1'b1;
    res = '0;
    if (req.action == ots_pkg::ACT_START) begin
      cal_busy = 1'b1;
      cal_region = 1'b0;
      cal_best = '0;
      cal_best_dev = ots_pkg::DEV_RESET;
      cal_step = ots_pkg::STEP_START;
      cal_trial = ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START);
      res.trim_value = cal_trial;
      n_starts++;
    end else if (!cal_busy) begin
      produced = 1'b0;
      n_ignored++;
    end else begin
      n_measures++;
      dev = (meas >= cal_target) ? meas - cal_target : cal_target - meas;
      if (ots_pkg::DEV_WIDTH'(dev) < cal_best_dev) begin
        cal_best = cal_trial;
        cal_best_dev = ots_pkg::DEV_WIDTH'(dev);
      end
      cal_step = cal_step >> 1;
      if (cal_step != '0) begin
        if (meas < cal_target) begin
          cal_trial = cal_trial + ots_pkg::TRIM_WIDTH'(cal_step);
        end else begin
          cal_trial = cal_trial - ots_pkg::TRIM_WIDTH'(cal_step);
        end
        res.trim_value = cal_trial;
      end else if (!cal_region) begin
        cal_region = 1'b1;
        cal_step = ots_pkg::STEP_START;
        cal_trial = ots_pkg::REGION1_BASE + ots_pkg::TRIM_WIDTH'(ots_pkg::STEP_START);
        res.trim_value = cal_trial;
      end else begin
        cal_busy = 1'b0;
        res.trim_value = cal_best;
        res.done_res = 1'b1;
        n_done++;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic send_request(input ots_pkg::ots_in_t req, input bit typed,
                              input bit silent, input ots_pkg::ots_out_t typed_res);
    int                gap;
    bit                produced;
    ots_pkg::ots_out_t res;
    if ($urandom_range(0, 15) == 0) begin
      feed_steady = !feed_steady;
    end
    gap = feed_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    advance_calibration(req, produced, res);
    if (typed) begin
      if (!silent) begin
        trims_due.push_back(typed_res);
      end
    end else if (produced) begin
      trims_due.push_back(res);
    end
    if (produced) begin
      n_answered++;
    end
  endtask

  task automatic add_row(input logic action, input int meas, input bit typed,
                         input bit silent, input int trim, input logic done);
    table_row_t row;
    row.req.action = action;
    row.req.measured_length = ots_pkg::MEASURE_WIDTH'(meas);
    row.typed = typed;
    row.silent = silent;
    row.res.trim_value = ots_pkg::TRIM_WIDTH'(trim);
    row.res.done_res = done;
    directed.push_back(row);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (trims_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [ots_pkg::MEASURE_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_target = value;
  endtask

  // mix of uniform lengths, lengths near the target, a plant-like response and edge values
  function automatic logic [ots_pkg::MEASURE_WIDTH-1:0] pick_length();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, MEAS_MAX));
      1: v = int'(cal_target) + int'($urandom_range(0, 64)) - 32;
      2: v = int'(cal_target) - 600 + 5 * int'(cal_trial) + int'($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = MEAS_MAX;
          default: v = int'(cal_target);
        endcase
      end
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > MEAS_MAX) begin
      v = MEAS_MAX;
    end
    return ots_pkg::MEASURE_WIDTH'(v);
  endfunction

  task automatic random_searches(input int quota);
    int               first;
    int               r;
    int               n;
    ots_pkg::ots_in_t req;
    first = n_answered;
    while (n_answered - first < quota) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        req.action = $urandom_range(0, 1) ? ots_pkg::ACT_MEASURE : ots_pkg::ACT_START;
        req.measured_length = ots_pkg::MEASURE_WIDTH'($urandom);
        send_request(req, 1'b0, 1'b0, '0);
      end else begin
        req.action = ots_pkg::ACT_START;
        req.measured_length = ots_pkg::MEASURE_WIDTH'($urandom);
        send_request(req, 1'b0, 1'b0, '0);
        n = (r < 22) ? $urandom_range(1, 13) : 14;
        repeat (n) begin
          req.action = ots_pkg::ACT_MEASURE;
          req.measured_length = pick_length();
          send_request(req, 1'b0, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [ots_pkg::MEASURE_WIDTH-1:0] targets[6];
    targets[0] = '0;
    targets[1] = ots_pkg::MEASURE_WIDTH'(MEAS_MAX);
    targets[2] = ots_pkg::TARGET_RESET;
    targets[3] = ots_pkg::MEASURE_WIDTH'($urandom_range(0, MEAS_MAX));
    targets[4] = ots_pkg::MEASURE_WIDTH'(1);
    targets[5] = ots_pkg::MEASURE_WIDTH'(MEAS_MAX - 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // measurement before any start, then a search that never beats the reset deviation
    add_row(ots_pkg::ACT_MEASURE, 5000, 1'b1, 1'b1, 0, 1'b0);
    add_row(ots_pkg::ACT_START, 0, 1'b1, 1'b0, 64, 1'b0);
    repeat (13) add_row(ots_pkg::ACT_MEASURE, MEAS_MAX, 1'b0, 1'b0, 0, 1'b0);
    add_row(ots_pkg::ACT_MEASURE, MEAS_MAX, 1'b1, 1'b0, 0, 1'b1);
    add_row(ots_pkg::ACT_MEASURE, 0, 1'b1, 1'b1, 0, 1'b0);
    // short first measurement moves up, then a restart while busy
    add_row(ots_pkg::ACT_START, MEAS_MAX, 1'b1, 1'b0, 64, 1'b0);
    add_row(ots_pkg::ACT_MEASURE, 0, 1'b1, 1'b0, 96, 1'b0);
    add_row(ots_pkg::ACT_START, 0, 1'b1, 1'b0, 64, 1'b0);
    add_row(ots_pkg::ACT_MEASURE, 2356, 1'b0, 1'b0, 0, 1'b0);
    add_row(ots_pkg::ACT_MEASURE, 1, 1'b0, 1'b0, 0, 1'b0);
    add_row(ots_pkg::ACT_MEASURE, 8192, 1'b0, 1'b0, 0, 1'b0);
    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].typed, directed[i].silent, directed[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_target(targets[ph]);
      if (ph == 2) begin
        long_hold_due <= 1'b1;
      end
      random_searches(255);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d starts, %0d measurements, %0d finished searches, %0d idle measurements",
             n_starts, n_measures, n_done, n_ignored);
    $display("%0d results checked over six target lengths including both extremes", n_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : sink
    int                stall;
    ots_pkg::ots_out_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        sink_steady = !sink_steady;
      end
      if (long_hold_due) begin
        stall = LONG_HOLD;
        long_hold_due <= 1'b0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (trims_due.size() == 0) begin
        note_mismatch("unrequested result, trim", -1, int'(out_data.trim_value));
      end else begin
        want = trims_due.pop_front();
        n_checked++;
        if (out_data.trim_value !== want.trim_value) begin
          note_mismatch("trim_value", int'(want.trim_value), int'(out_data.trim_value));
        end
        if (out_data.done_res !== want.done_res) begin
          note_mismatch("done_res", int'(want.done_res), int'(out_data.done_res));
        end
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
